FILE: rtl/ba_pkg.sv
// Shared types and constants of the buddy allocator.
// Holds the controller state encoding and the command and status bundles
// that join the controller to the datapath. No dependencies.
`default_nettype none

package ba_pkg;

  // Fixed field widths of the stream and configuration payloads.
  localparam int AXW        = 48;
  localparam int SZW        = 17;
  localparam int OW         = 5;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 56;

  // Block flag bits kept beside each block order.
  localparam logic [1:0] FLAG_CLEAR = 2'b00;
  localparam logic [1:0] FLAG_START = 2'b01;
  localparam logic [1:0] FLAG_USED  = 2'b10;

  // Operation codes carried in tuser.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_OOM     = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  // Configuration register indexes.
  localparam logic REG_POOL_SIZE    = 1'b0;
  localparam logic REG_BASE_ADDRESS = 1'b1;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_CLR,
    ST_DECOMP,
    ST_DADV,
    ST_IDLE,
    ST_ASIZE,
    ST_ASRCH,
    ST_ASPLIT,
    ST_AADV,
    ST_FOFF,
    ST_FRD,
    ST_FCHK,
    ST_FMRG,
    ST_FBRD,
    ST_FBCHK,
    ST_FUL2,
    ST_FHI,
    ST_PUSH1,
    ST_PUSH2,
    ST_ULRD,
    ST_ULWR,
    ST_DONE
  } state_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic init;
    logic clr_wr;
    logic ld_in;
    logic k_inc;
    logic j_start;
    logic j_inc;
    logic take_head;
    logic rd_bud;
    logic push1;
    logic push2;
    logic ul_wr;
    logic ord_dec;
    logic split_adv;
    logic mark;
    logic dec_adv;
    logic set_oom;
    logic set_inv;
    logic off_ld;
    logic ord_meta;
    logic bud_ld;
    logic merge_up;
    logic out_load;
  } cmd_t;

  // Datapath conditions reported to the controller.
  typedef struct packed {
    logic size_gt;
    logic j_ovf;
    logic head_ok;
    logic split_more;
    logic rem_ge;
    logic ord_zero;
    logic clr_last;
    logic o_ok;
    logic used_ok;
    logic can_merge;
    logic b_ok;
    logic bud_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/ba_dpath.sv
// Datapath of the buddy allocator: block metadata and free-list link
// memories, list heads, work registers and the result register.
// Depends on ba_pkg.
`default_nettype none

module ba_dpath #(
  parameter int POOL_MAX = 65536,
  parameter int ORDERS   = 17
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ba_pkg::cmd_t              cmd,
  output ba_pkg::sts_t              sts,
  input  logic                      cfg_pool_wr,
  input  logic                      cfg_base_wr,
  input  logic [ba_pkg::AXW-1:0]    cfg_data,
  input  logic [ba_pkg::SZW-1:0]    in_size,
  input  logic [ba_pkg::AXW-1:0]    in_baddr,
  output logic [ba_pkg::AXW-1:0]    out_address,
  output logic [1:0]                out_status
);
  import ba_pkg::*;

  localparam int AW       = $clog2(POOL_MAX);
  localparam int PW       = $clog2(POOL_MAX + 1);
  localparam int KW       = $clog2(ORDERS);
  localparam int POOL_RST = (POOL_MAX < 65536) ? POOL_MAX : 65536;
  localparam logic [PW-1:0] NONE = PW'(POOL_MAX);

  // Configuration registers.
  logic [PW-1:0]  pool;
  logic [AXW-1:0] base;

  // Work registers.
  logic [SZW-1:0] req_size;
  logic [AXW-1:0] blk_addr;
  logic [AW-1:0]  off;
  logic [AW-1:0]  bud;
  logic [OW-1:0]  ord;
  logic [OW-1:0]  kreq;
  logic [PW-1:0]  rem;
  logic [PW-1:0]  tmp;
  logic [AXW-1:0] res_addr;
  logic [1:0]     res_status;
  logic [PW-1:0]  head [ORDERS];

  // Memories: {order, flags} per offset and the two link arrays.
  logic [OW+1:0]  meta [POOL_MAX];
  logic [PW-1:0]  nxt  [POOL_MAX];
  logic [PW-1:0]  prv  [POOL_MAX];
  logic [OW+1:0]  meta_q;
  logic [PW-1:0]  nxt_q;
  logic [PW-1:0]  prv_q;

  logic [AW-1:0]  rd_addr;
  logic           ord_ok;
  logic [KW-1:0]  hidx;
  logic [PW-1:0]  head_rd;
  logic [OW-1:0]  q_ord;
  logic [1:0]     q_flags;
  logic [KW-1:0]  q_idx;
  logic           q_ok;
  logic           p_live;
  logic           n_live;
  logic [PW-1:0]  sz;
  logic [AW-1:0]  step;
  logic [AXW-1:0] o_diff;
  logic [31:0]    bwide;
  logic [AW-1:0]  lo;
  logic [AW-1:0]  hi;
  logic [SZW-1:0] pow_k;
  logic [31:0]    cfg_pool_ext;

  logic           meta_we;
  logic [AW-1:0]  meta_wa;
  logic [OW+1:0]  meta_wd;
  logic           nxt_we;
  logic [AW-1:0]  nxt_wa;
  logic [PW-1:0]  nxt_wd;
  logic           prv_we;
  logic [AW-1:0]  prv_wa;
  logic [PW-1:0]  prv_wd;

  // Derived values and conditions.
  always_comb begin
    ord_ok  = ord < OW'(ORDERS);
    hidx    = ord[KW-1:0];
    head_rd = ord_ok ? head[hidx] : NONE;
    q_ord   = meta_q[OW+1:2];
    q_flags = meta_q[1:0];
    q_idx   = q_ord[KW-1:0];
    q_ok    = q_ord < OW'(ORDERS);
    p_live  = prv_q < NONE;
    n_live  = nxt_q < NONE;
    sz      = PW'(1) << ord;
    step    = AW'(1) << ord;
    pow_k   = SZW'(1) << kreq;
    o_diff  = blk_addr - base;
    bwide   = 32'(off) ^ (32'd1 << ord);
    lo      = (off < bud) ? off : bud;
    hi      = (off < bud) ? bud : off;
    rd_addr = cmd.rd_bud ? bud : off;
    cfg_pool_ext = 32'(cfg_data[SZW-1:0]);

    sts.size_gt    = (kreq < OW'(ORDERS)) && (int'(kreq) < SZW) && (pow_k < req_size);
    sts.j_ovf      = !ord_ok;
    sts.head_ok    = head_rd < NONE;
    sts.split_more = ord > kreq;
    sts.rem_ge     = (int'(ord) < PW) && (rem >= sz);
    sts.ord_zero   = ord == '0;
    sts.clr_last   = off == AW'(POOL_MAX - 1);
    sts.o_ok       = o_diff < AXW'(POOL_MAX);
    sts.used_ok    = (q_flags == (FLAG_START | FLAG_USED)) && q_ok;
    sts.can_merge  = ((6'(ord) + 6'd1) < 6'(ORDERS));
    sts.b_ok       = bwide < 32'(POOL_MAX);
    sts.bud_free   = (q_flags == FLAG_START) && (q_ord == ord);
  end

  // Metadata write port selection.
  always_comb begin
    meta_we = 1'b0;
    meta_wa = off;
    meta_wd = '0;
    priority if (cmd.clr_wr) begin
      meta_we = 1'b1;
    end else if (cmd.push1) begin
      meta_we = 1'b1;
      meta_wd = {ord, FLAG_START};
    end else if (cmd.mark) begin
      meta_we = 1'b1;
      meta_wd = {kreq, FLAG_START | FLAG_USED};
    end else if (cmd.merge_up) begin
      meta_we = 1'b1;
      meta_wa = hi;
      meta_wd = {ord, FLAG_CLEAR};
    end
  end

  // Link write port selection.
  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = off;
    nxt_wd = head_rd;
    prv_we = 1'b0;
    prv_wa = off;
    prv_wd = NONE;
    if (cmd.push1) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else if (cmd.push2) begin
      prv_we = tmp < NONE;
      prv_wa = tmp[AW-1:0];
      prv_wd = PW'(off);
    end else if (cmd.ul_wr) begin
      nxt_we = q_ok && p_live;
      nxt_wa = prv_q[AW-1:0];
      nxt_wd = nxt_q;
      prv_we = q_ok && n_live;
      prv_wa = nxt_q[AW-1:0];
      prv_wd = prv_q;
    end
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta[meta_wa] <= meta_wd;
    end
    if (nxt_we) begin
      nxt[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv[prv_wa] <= prv_wd;
    end
    meta_q <= meta[rd_addr];
    nxt_q  <= nxt[rd_addr];
    prv_q  <= prv[rd_addr];
  end

  // Configuration registers; pool size saturates at the pool capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= PW'(POOL_RST);
      base <= '0;
    end else begin
      if (cfg_pool_wr) begin
        pool <= (cfg_pool_ext > 32'(POOL_MAX)) ? NONE : PW'(cfg_pool_ext);
      end
      if (cfg_base_wr) begin
        base <= cfg_data;
      end
    end
  end

  // List heads.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < ORDERS; i++) begin
        head[i] <= NONE;
      end
    end else if (cmd.push1) begin
      head[hidx] <= PW'(off);
    end else if (cmd.ul_wr && q_ok && !p_live) begin
      head[q_idx] <= nxt_q;
    end
  end

  // Work registers.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      off <= '0;
      ord <= OW'(ORDERS - 1);
      rem <= pool;
    end
    if (cmd.clr_wr) begin
      off <= sts.clr_last ? '0 : off + AW'(1);
    end
    if (cmd.ld_in) begin
      req_size   <= in_size;
      blk_addr   <= in_baddr;
      kreq       <= '0;
      res_addr   <= '0;
      res_status <= STAT_OK;
    end
    if (cmd.k_inc) begin
      kreq <= kreq + OW'(1);
    end
    if (cmd.j_start) begin
      ord <= kreq;
    end
    if (cmd.j_inc) begin
      ord <= ord + OW'(1);
    end
    if (cmd.take_head) begin
      off <= head_rd[AW-1:0];
    end
    if (cmd.push1) begin
      tmp <= head_rd;
    end
    if (cmd.ord_dec) begin
      ord <= ord - OW'(1);
    end
    if (cmd.split_adv) begin
      off <= off + step;
    end
    if (cmd.mark) begin
      res_addr <= base + AXW'(off);
    end
    if (cmd.dec_adv) begin
      rem <= rem - sz;
      off <= off + step;
    end
    if (cmd.set_oom) begin
      res_status <= STAT_OOM;
    end
    if (cmd.set_inv) begin
      res_status <= STAT_INVALID;
    end
    if (cmd.off_ld) begin
      off <= o_diff[AW-1:0];
    end
    if (cmd.ord_meta) begin
      ord <= q_ord;
    end
    if (cmd.bud_ld) begin
      bud <= bwide[AW-1:0];
    end
    if (cmd.merge_up) begin
      off <= lo;
      ord <= ord + OW'(1);
    end
    if (cmd.out_load) begin
      out_address <= res_addr;
      out_status  <= res_status;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ba_ctrl.sv
// Controller of the buddy allocator: sequences the clearing pass, the pool
// decomposition, allocate and free, and owns the result valid flag.
// Depends on ba_pkg.
`default_nettype none

module ba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_pool_wr,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ba_pkg::sts_t  sts,
  output ba_pkg::cmd_t  cmd
);
  import ba_pkg::*;

  state_t state;
  state_t state_next;
  state_t ret;
  state_t ret_next;
  logic   ulb;
  logic   ulb_next;

  // State, return point and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      ret       <= ST_IDLE;
      ulb       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      ulb   <= ulb_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ret_next   = ret;
    ulb_next   = ulb;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_CLR;
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_DECOMP;
        end
      end
      ST_DECOMP: begin
        if (sts.rem_ge) begin
          ret_next   = ST_DADV;
          state_next = ST_PUSH1;
        end else if (sts.ord_zero) begin
          state_next = ST_IDLE;
        end else begin
          cmd.ord_dec = 1'b1;
        end
      end
      ST_DADV: begin
        cmd.dec_adv = 1'b1;
        state_next  = ST_DECOMP;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = (in_func == FUNC_FREE) ? ST_FOFF : ST_ASIZE;
        end
      end
      ST_ASIZE: begin
        if (sts.size_gt) begin
          cmd.k_inc = 1'b1;
        end else begin
          cmd.j_start = 1'b1;
          state_next  = ST_ASRCH;
        end
      end
      ST_ASRCH: begin
        if (sts.j_ovf) begin
          cmd.set_oom = 1'b1;
          state_next  = ST_DONE;
        end else if (sts.head_ok) begin
          cmd.take_head = 1'b1;
          ulb_next      = 1'b0;
          ret_next      = ST_ASPLIT;
          state_next    = ST_ULRD;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      ST_ASPLIT: begin
        if (sts.split_more) begin
          cmd.ord_dec = 1'b1;
          ret_next    = ST_AADV;
          state_next  = ST_PUSH1;
        end else begin
          cmd.mark   = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_AADV: begin
        cmd.split_adv = 1'b1;
        state_next    = ST_ASPLIT;
      end
      ST_FOFF: begin
        if (sts.o_ok) begin
          cmd.off_ld = 1'b1;
          state_next = ST_FRD;
        end else begin
          cmd.set_inv = 1'b1;
          state_next  = ST_DONE;
        end
      end
      ST_FRD: begin
        state_next = ST_FCHK;
      end
      ST_FCHK: begin
        if (sts.used_ok) begin
          cmd.ord_meta = 1'b1;
          ret_next     = ST_FMRG;
          state_next   = ST_PUSH1;
        end else begin
          cmd.set_inv = 1'b1;
          state_next  = ST_DONE;
        end
      end
      ST_FMRG: begin
        if (sts.can_merge && sts.b_ok) begin
          cmd.bud_ld = 1'b1;
          state_next = ST_FBRD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FBRD: begin
        cmd.rd_bud = 1'b1;
        state_next = ST_FBCHK;
      end
      ST_FBCHK: begin
        if (sts.bud_free) begin
          ulb_next   = 1'b1;
          ret_next   = ST_FUL2;
          state_next = ST_ULRD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FUL2: begin
        ulb_next   = 1'b0;
        ret_next   = ST_FHI;
        state_next = ST_ULRD;
      end
      ST_FHI: begin
        cmd.merge_up = 1'b1;
        ret_next     = ST_FMRG;
        state_next   = ST_PUSH1;
      end
      ST_PUSH1: begin
        cmd.push1  = 1'b1;
        state_next = ST_PUSH2;
      end
      ST_PUSH2: begin
        cmd.push2  = 1'b1;
        state_next = ret;
      end
      ST_ULRD: begin
        cmd.rd_bud = ulb;
        state_next = ST_ULWR;
      end
      ST_ULWR: begin
        cmd.ul_wr  = 1'b1;
        state_next = ret;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
    // A pool size write rebuilds the whole pool.
    if (cfg_pool_wr) begin
      state_next = ST_INIT;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/buddy_allocator.sv
// Binary buddy allocator: one request in, one result out per transfer.
// Each request is worked through by the controller's walk over the orders,
// with the list memory reads registered.
// After reset or a pool_size write the block runs a clearing pass over
// the metadata memory, then lays out the pool; no request is taken then.
// A new request is taken while a finished result still waits on the output.
// Depends on ba_pkg, ba_ctrl and ba_dpath.
`default_nettype none

module buddy_allocator #(
  parameter int POOL_MAX = 65536,
  parameter int ORDERS   = 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // request_size [16:0], block_address [64:17], zero padding above
  input  logic [ba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // func [0]
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // address [47:0], status [49:48], zero padding above
  output logic [ba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [0:0]                      cfg_index,
  input  logic [ba_pkg::AXW-1:0]          cfg_data
);
  import ba_pkg::*;

  cmd_t           cmd;
  sts_t           sts;
  logic           cfg_pool_wr;
  logic           cfg_base_wr;
  logic [AXW-1:0] out_address;
  logic [1:0]     out_status;

  // Configuration writes are always taken.
  assign cfg_ready   = 1'b1;
  assign cfg_pool_wr = cfg_valid && (cfg_index[0] == REG_POOL_SIZE);
  assign cfg_base_wr = cfg_valid && (cfg_index[0] == REG_BASE_ADDRESS);

  ba_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_pool_wr (cfg_pool_wr),
    .in_valid    (s_axis_tvalid),
    .in_func     (s_axis_tuser[0]),
    .in_ready    (s_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .sts         (sts),
    .cmd         (cmd)
  );

  ba_dpath #(
    .POOL_MAX (POOL_MAX),
    .ORDERS   (ORDERS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_pool_wr (cfg_pool_wr),
    .cfg_base_wr (cfg_base_wr),
    .cfg_data    (cfg_data),
    .in_size     (s_axis_tdata[SZW-1:0]),
    .in_baddr    (s_axis_tdata[SZW+AXW-1:SZW]),
    .out_address (out_address),
    .out_status  (out_status)
  );

  // Result packing.
  assign m_axis_tdata = {{(OUT_TDATA_W - AXW - 2){1'b0}}, out_status, out_address};

  // One request is worked on at a time.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[AXW+1:AXW] == STAT_OK ||
                       m_axis_tdata[AXW+1:AXW] == STAT_OOM ||
                       m_axis_tdata[AXW+1:AXW] == STAT_INVALID))
    else $error("undefined status code on result");

  // Failed requests carry a zero address.
  a_error_address: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[AXW+1:AXW] != STAT_OK) |->
      (m_axis_tdata[AXW-1:0] == '0))
    else $error("error result with nonzero address");

endmodule

`default_nettype wire

FILE: tb/sv/tb_buddy_allocator.sv
// Self-checking testbench for the buddy allocator stream block.
// Predicts every result with a local model of the free lists and compares it
// field by field; depends on ba_pkg and buddy_allocator.
module tb_buddy_allocator;
  import ba_pkg::*;

  localparam int POOL_MAX = 65536;
  localparam int ORDERS   = 17;
  localparam int NIL      = POOL_MAX;
  localparam int SETTLE   = 60;
  localparam int WD_LIMIT = 300000;

  typedef enum logic {K_REQ, K_REG} kind_t;

  typedef struct {
    kind_t             kind;
    logic              func;
    logic [SZW-1:0]    size;
    logic [AXW-1:0]    addr;
    logic [0:0]        idx;
    logic [AXW-1:0]    data;
  } entry_t;

  typedef struct {
    logic           func;
    logic [AXW-1:0] addr;
    logic [1:0]     status;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [AXW-1:0] cfg_data = '0;

  buddy_allocator DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the allocator state.
  logic [4:0]  blk_order [POOL_MAX];
  logic [1:0]  blk_flags [POOL_MAX];
  int unsigned link_prev [POOL_MAX];
  int unsigned link_next [POOL_MAX];
  int unsigned list_front [ORDERS];
  int unsigned pool_bytes;
  logic [AXW-1:0] base_addr;

  entry_t   pending[$];
  result_t  awaited[$];
  logic [AXW-1:0] live_blocks[$];
  logic [AXW-1:0] freed_blocks[$];
  int errors = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  function automatic void push_block(int unsigned off, int unsigned k);
    int unsigned h;
    h = list_front[k];
    blk_order[off] = k[4:0];
    blk_flags[off] = FLAG_START;
    link_prev[off] = NIL;
    link_next[off] = h;
    if (h < NIL) link_prev[h] = off;
    list_front[k] = off;
  endfunction

  function automatic void unlink_block(int unsigned off);
    int unsigned k, p, n;
    k = blk_order[off];
    p = link_prev[off];
    n = link_next[off];
    if (k < ORDERS) begin
      if (p < NIL) link_next[p] = n; else list_front[k] = n;
      if (n < NIL) link_prev[n] = p;
    end
  endfunction

  // Lay the pool out as aligned power-of-two blocks, largest first.
  function automatic void lay_out_pool();
    longint unsigned rem, off, sz;
    for (int i = 0; i < POOL_MAX; i++) begin
      blk_order[i] = '0;
      blk_flags[i] = FLAG_CLEAR;
      link_prev[i] = 0;
      link_next[i] = 0;
    end
    for (int k = 0; k < ORDERS; k++) list_front[k] = NIL;
    rem = pool_bytes;
    off = 0;
    for (int k = ORDERS - 1; k >= 0; k--) begin
      sz = 64'd1 << k;
      while (rem >= sz && off + sz <= POOL_MAX) begin
        push_block(off, k);
        rem -= sz;
        off += sz;
      end
    end
  endfunction

  function automatic void write_register(logic [0:0] idx, logic [AXW-1:0] data);
    if (idx == REG_POOL_SIZE) begin
      pool_bytes = data[SZW-1:0] > POOL_MAX ? POOL_MAX : data[SZW-1:0];
      lay_out_pool();
    end else begin
      base_addr = data;
    end
  endfunction

  function automatic result_t serve_request(logic func, logic [SZW-1:0] size,
                                            logic [AXW-1:0] addr);
    result_t r;
    int unsigned k, j, off;
    logic [AXW-1:0] o;
    longint unsigned b;
    r.func = func;
    r.addr = '0;
    r.status = STAT_OK;
    if (func == FUNC_ALLOC) begin
      k = 0;
      while (k < ORDERS && (64'd1 << k) < size) k++;
      j = k;
      while (j < ORDERS && list_front[j] >= NIL) j++;
      if (k >= ORDERS || j >= ORDERS) begin
        r.status = STAT_OOM;
      end else begin
        off = list_front[j];
        unlink_block(off);
        while (j > k) begin
          j--;
          push_block(off, j);
          off += 1 << j;
        end
        blk_order[off] = k[4:0];
        blk_flags[off] = FLAG_START | FLAG_USED;
        r.addr = base_addr + AXW'(off);
      end
    end else begin
      o = addr - base_addr;
      if (o >= POOL_MAX || blk_flags[o[15:0]] != (FLAG_START | FLAG_USED)
          || blk_order[o[15:0]] >= ORDERS) begin
        r.status = STAT_INVALID;
      end else begin
        off = o;
        k = blk_order[off];
        push_block(off, k);
        // Merge with free buddies of equal order while they exist.
        while (k + 1 < ORDERS) begin
          b = off ^ (1 << k);
          if (b >= POOL_MAX) break;
          if (blk_flags[b] != FLAG_START || blk_order[b] != k) break;
          unlink_block(b);
          unlink_block(off);
          blk_flags[off ^ (off < b ? off : b) ^ b] = FLAG_CLEAR;
          if (b < off) off = b;
          k++;
          push_block(off, k);
        end
      end
    end
    return r;
  endfunction

  // Driver: request and register transfers, sent in bursts with gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic   nv, ncv;
    entry_t e;
    result_t r;
    nv = s_axis_tvalid;
    ncv = cfg_valid;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        r = serve_request(s_axis_tuser[0], s_axis_tdata[SZW-1:0],
                          s_axis_tdata[SZW+AXW-1:SZW]);
        awaited.push_back(r);
        nv = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        write_register(cfg_index, cfg_data);
        ncv = 1'b0;
      end
      quiet_cycles = (awaited.size() == 0 && !nv) ? quiet_cycles + 1 : 0;
      if (!nv && !ncv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          e = pending[0];
          if (e.kind == K_REQ) begin
            void'(pending.pop_front());
            s_axis_tdata <= {7'd0, e.addr, e.size};
            s_axis_tuser <= e.func;
            nv = 1'b1;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end else if (quiet_cycles >= SETTLE) begin
            void'(pending.pop_front());
            cfg_index <= e.idx;
            cfg_data <= e.data;
            ncv = 1'b1;
          end
        end
      end
    end
    s_axis_tvalid <= nv;
    cfg_valid <= ncv;
  end

  // Receiver: stalls on its own pattern, with one long hold-off.
  int hold_left = 0;
  bit held = 1'b0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!held && results_seen == 150) begin
      held = 1'b1;
      hold_left = 600;
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    result_t x;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        $error("unexpected result transfer: address %h status %0d",
               m_axis_tdata[AXW-1:0], m_axis_tdata[AXW+1:AXW]);
        errors++;
      end else begin
        x = awaited.pop_front();
        if (m_axis_tdata[AXW-1:0] !== x.addr) begin
          $error("address: expected %h, actual %h", x.addr, m_axis_tdata[AXW-1:0]);
          errors++;
        end
        if (m_axis_tdata[AXW+1:AXW] !== x.status) begin
          $error("status: expected %0d, actual %0d", x.status,
                 m_axis_tdata[AXW+1:AXW]);
          errors++;
        end
        if (x.func == FUNC_ALLOC && x.status == STAT_OK) live_blocks.push_back(x.addr);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  int idle_count = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WD_LIMIT) begin
      $display("tb_buddy_allocator: errors");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic add_alloc(logic [SZW-1:0] size);
    entry_t e;
    e.kind = K_REQ; e.func = FUNC_ALLOC; e.size = size;
    e.addr = AXW'({$urandom, $urandom}); e.idx = '0; e.data = '0;
    pending.push_back(e);
  endtask

  task automatic add_free(logic [AXW-1:0] addr);
    entry_t e;
    e.kind = K_REQ; e.func = FUNC_FREE; e.addr = addr;
    e.size = SZW'($urandom); e.idx = '0; e.data = '0;
    pending.push_back(e);
  endtask

  task automatic add_reg(logic [0:0] idx, logic [AXW-1:0] data);
    entry_t e;
    e.kind = K_REG; e.idx = idx; e.data = data;
    e.func = FUNC_ALLOC; e.size = '0; e.addr = '0;
    pending.push_back(e);
  endtask

  // Sender pause: wait until every queued transfer is out and every result in.
  task automatic drain();
    @(posedge clk);
    while (pending.size() > 0 || s_axis_tvalid || cfg_valid || awaited.size() > 0)
      @(posedge clk);
  endtask

  task automatic free_live(int i);
    logic [AXW-1:0] a;
    a = live_blocks[i];
    live_blocks.delete(i);
    freed_blocks.push_back(a);
    if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
    add_free(a);
  endtask

  // Random traffic: mostly allocs and frees of live blocks, some broken frees.
  task automatic random_phase(int n);
    int c;
    logic [AXW-1:0] a;
    for (int i = 0; i < n; i++) begin
      while (pending.size() > 4) @(posedge clk);
      c = $urandom_range(0, 99);
      if (c < 50) begin
        if ($urandom_range(0, 9) == 0) add_alloc(SZW'($urandom));
        else add_alloc(SZW'($urandom_range(0, 1 << $urandom_range(0, 12))));
      end else if (c < 88 && live_blocks.size() > 0) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else if (c < 93 && freed_blocks.size() > 0) begin
        add_free(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
      end else if (c < 96) begin
        add_free(AXW'({$urandom, $urandom}));
      end else begin
        a = base_addr + AXW'($urandom_range(0, POOL_MAX + 8));
        add_free(a);
      end
    end
  endtask

  task automatic new_setting(logic [AXW-1:0] pool, logic [AXW-1:0] base, int n);
    drain();
    live_blocks.delete();
    freed_blocks.delete();
    add_reg(REG_BASE_ADDRESS, base);
    add_reg(REG_POOL_SIZE, pool);
    random_phase(n);
  endtask

  initial begin
    pool_bytes = POOL_MAX;
    base_addr = '0;
    lay_out_pool();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: whole pool, out of memory, oversized and broken frees.
    add_alloc(17'd65536);
    add_alloc(17'd1);
    add_alloc(17'h1FFFF);
    drain();
    free_live(0);
    add_free(48'd0);
    add_free(48'hFFFF_FFFF_FFFF);
    add_alloc(17'd0);
    add_alloc(17'd1);
    add_alloc(17'd2);
    add_alloc(17'd3);
    add_alloc(17'd5);
    add_alloc(17'd4096);
    add_alloc(17'd32768);
    drain();
    add_free(live_blocks[2] + 48'd1);
    for (int i = live_blocks.size() - 1; i >= 0; i--) free_live(i);
    add_free(freed_blocks[0]);
    random_phase(90);

    new_setting(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 90);
    new_setting(48'd1, AXW'({$urandom, $urandom}), 40);
    new_setting(48'd0, AXW'({$urandom, $urandom}), 30);
    new_setting(48'd40000, 48'hFFFF_FFFF_F000, 110);
    new_setting(48'd37, AXW'({$urandom, $urandom}), 90);
    new_setting(48'd65536, 48'd0, 90);

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("tb_buddy_allocator: clean");
    end else begin
      $display("tb_buddy_allocator: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ba_pkg.sv
rtl/ba_dpath.sv
rtl/ba_ctrl.sv
rtl/buddy_allocator.sv
tb/sv/tb_buddy_allocator.sv
